### design/bta_pkg.sv
// Bakery ticket arbiter: shared sizes, codes and the structs that run
// between the controller and the ticket cells. No dependencies.
`default_nettype none

package bta_pkg;

  localparam int REQUESTERS  = 8;
  localparam int TICKET_BITS = 16;

  localparam int CNT_W = $clog2(REQUESTERS + 1);
  localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;

  localparam logic [3:0] CFG_RESET = 4'd8;

  typedef logic [TICKET_BITS-1:0] ticket_t;
  typedef logic [CMP_W-1:0]       slot_t;

  typedef enum logic [0:0] {
    KIND_REQUEST = 1'b0,
    KIND_RELEASE = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ERR_OK      = 2'd0,
    ERR_RANGE   = 2'd1,
    ERR_EXHAUST = 2'd2
  } err_e;

  // Scan bundle handed from cell to cell: running max and smallest pair.
  typedef struct packed {
    logic    tok;
    ticket_t max;
    logic    found;
    ticket_t best_t;
    slot_t   best_id;
  } scan_t;

  // Ticket write broadcast from the controller to all cells.
  typedef struct packed {
    logic    en;
    slot_t   id;
    ticket_t data;
  } wr_t;

endpackage

`default_nettype wire

### design/bta_req_if.sv
// Request channel of the bakery ticket arbiter: valid/ready plus payload.
// No dependencies.
`default_nettype none

interface bta_req_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [2:0] requester;

  modport source (output valid, kind, requester, input ready);
  modport sink   (input valid, kind, requester, output ready);
endinterface

`default_nettype wire

### design/bta_rsp_if.sv
// Result channel of the bakery ticket arbiter: valid/ready plus grant payload.
// No dependencies.
`default_nettype none

interface bta_rsp_if;
  logic        valid;
  logic        ready;
  logic        grant_valid;
  logic [2:0]  grant_id;
  logic [15:0] ticket_given;
  logic [1:0]  error;

  modport source (output valid, grant_valid, grant_id, ticket_given, error, input ready);
  modport sink   (input valid, grant_valid, grant_id, ticket_given, error, output ready);
endinterface

`default_nettype wire

### design/bta_cfg_if.sv
// Configuration write channel of the bakery ticket arbiter (one register).
// No dependencies.
`default_nettype none

interface bta_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] active_requesters;

  modport source (output valid, active_requesters, input ready);
  modport sink   (input valid, active_requesters, output ready);
endinterface

`default_nettype wire

### design/bta_cell.sv
// One ticket slot of the arbiter chain: holds its ticket and folds it into
// the scan bundle passing by. Depends on bta_pkg.
`default_nettype none

module bta_cell (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire bta_pkg::slot_t cell_id_i,
  input  wire bta_pkg::slot_t count_i,
  input  wire bta_pkg::wr_t   wr_i,
  input  wire bta_pkg::scan_t scan_i,
  output bta_pkg::scan_t      scan_o
);
  import bta_pkg::*;

  ticket_t ticket_q;
  ticket_t ticket_cur;
  scan_t   scan_d;
  scan_t   scan_q;
  logic    tok_q;
  logic    active;
  logic    take;

  always_comb begin
    // see a ticket written this cycle as the token passes
    ticket_cur = (wr_i.en && (wr_i.id == cell_id_i)) ? wr_i.data : ticket_q;
    active = (cell_id_i < count_i);
    take   = active && (ticket_cur != '0) &&
             (!scan_i.found || (ticket_cur < scan_i.best_t));
    scan_d = scan_i;
    if (active && (ticket_cur > scan_i.max)) begin
      scan_d.max = ticket_cur;
    end
    if (take) begin
      scan_d.found   = 1'b1;
      scan_d.best_t  = ticket_cur;
      scan_d.best_id = cell_id_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticket_q <= '0;
      tok_q    <= 1'b0;
    end else begin
      tok_q <= scan_i.tok;
      if (wr_i.en && (wr_i.id == cell_id_i)) begin
        ticket_q <= wr_i.data;
      end
    end
  end

  // Capture the bundle only as the token passes.
  always_ff @(posedge clk_i) begin
    if (scan_i.tok) begin
      scan_q <= scan_d;
    end
  end

  always_comb begin
    scan_o     = scan_q;
    scan_o.tok = tok_q;
  end

endmodule

`default_nettype wire

### design/bakery_ticket_arbiter.sv
// Top level of the bakery ticket arbiter: controller, chain of ticket cells,
// result register. Depends on bta_pkg, bta_req_if, bta_rsp_if, bta_cfg_if, bta_cell.
//
//   channel  dir  handshake          payload
//   req_i    in   valid/ready        kind, requester
//   rsp_o    out  valid/ready        grant_valid, grant_id, ticket_given, error
//   cfg_i    in   valid/ready        active_requesters
//
// A request in range is offered as a result once a scan token has walked the cell
// chain twice: once for the maximum ticket, then, as the ticket is written, again
// for the smallest (ticket, id) pair. An id out of range skips the first walk.
// Reset clears all tickets at once and sets the active count to eight.
// A new request is taken once the previous result sits in the output register;
// a stalled result blocks only the loading of the next one.
`default_nettype none

module bakery_ticket_arbiter (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bta_req_if.sink    req_i,
  bta_rsp_if.source  rsp_o,
  bta_cfg_if.sink    cfg_i
);
  import bta_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MAX  = 4'b0010,
    ST_MIN  = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e      state_q, state_d;
  logic [3:0]  cfg_q;
  slot_t       count;
  kind_e       kind_q, kind_d;
  slot_t       who_q, who_d;
  logic [15:0] given_q, given_d;
  err_e        err_q, err_d;
  logic        gv_q, gv_d;
  slot_t       gid_q, gid_d;
  logic        launch;
  logic        load_rsp;
  wr_t         wr;
  ticket_t     next_ticket;
  scan_t       seed;
  scan_t       chain [REQUESTERS+1];
  scan_t       tail;
  logic [REQUESTERS-1:0] tok_vec;

  logic        rsp_valid_q;
  logic        rsp_gv_q;
  logic [2:0]  rsp_gid_q;
  logic [15:0] rsp_given_q;
  err_e        rsp_err_q;

  assign count = (CMP_W'(cfg_q) > CMP_W'(REQUESTERS)) ? CMP_W'(REQUESTERS) : CMP_W'(cfg_q);
  assign cfg_i.ready = 1'b1;
  assign req_i.ready = (state_q == ST_IDLE);

  always_comb begin
    seed         = '0;
    seed.tok     = launch;
  end

  assign chain[0] = seed;

  for (genvar g = 0; g < REQUESTERS; g++) begin : g_cell
    bta_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cell_id_i (CMP_W'(g)),
      .count_i   (count),
      .wr_i      (wr),
      .scan_i    (chain[g]),
      .scan_o    (chain[g+1])
    );
    assign tok_vec[g] = chain[g+1].tok;
  end

  assign tail        = chain[REQUESTERS];
  assign next_ticket = tail.max + ticket_t'(1);

  always_comb begin
    state_d  = state_q;
    kind_d   = kind_q;
    who_d    = who_q;
    given_d  = given_q;
    err_d    = err_q;
    gv_d     = gv_q;
    gid_d    = gid_q;
    launch   = 1'b0;
    load_rsp = 1'b0;
    wr       = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          kind_d  = kind_e'(req_i.kind);
          who_d   = CMP_W'(req_i.requester);
          given_d = '0;
          launch  = 1'b1;
          if (CMP_W'(req_i.requester) < count) begin
            err_d   = ERR_OK;
            state_d = ST_MAX;
          end else begin
            // out of range: skip the update, still report the grant
            err_d   = ERR_RANGE;
            state_d = ST_MIN;
          end
        end
      end
      ST_MAX: begin
        if (tail.tok) begin
          wr.id = who_q;
          if (kind_q == KIND_RELEASE) begin
            wr.en = 1'b1;
          end else if (&tail.max) begin
            err_d = ERR_EXHAUST;
          end else begin
            wr.en   = 1'b1;
            wr.data = next_ticket;
            given_d = 16'(next_ticket);
          end
          launch  = 1'b1;
          state_d = ST_MIN;
        end
      end
      ST_MIN: begin
        if (tail.tok) begin
          gv_d    = tail.found;
          gid_d   = tail.best_id;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          load_rsp = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_q       <= CFG_RESET;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) begin
        cfg_q <= cfg_i.active_requesters;
      end
      if (load_rsp) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    who_q   <= who_d;
    given_q <= given_d;
    err_q   <= err_d;
    gv_q    <= gv_d;
    gid_q   <= gid_d;
    if (load_rsp) begin
      rsp_gv_q    <= gv_q;
      rsp_gid_q   <= gv_q ? 3'(gid_q) : 3'd0;
      rsp_given_q <= given_q;
      rsp_err_q   <= err_q;
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.grant_valid  = rsp_gv_q;
  assign rsp_o.grant_id     = rsp_gid_q;
  assign rsp_o.ticket_given = rsp_given_q;
  assign rsp_o.error        = rsp_err_q;

  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vec))
    else $error("more than one scan token in the cell chain");

  a_rsp_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result raised outside the done state");

  a_refused_no_ticket: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && (rsp_err_q != ERR_OK)) |-> (rsp_given_q == 16'd0))
    else $error("refused request reports a ticket");

  a_no_grant_id_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && !rsp_gv_q) |-> (rsp_gid_q == 3'd0))
    else $error("grant id nonzero without a grant");

endmodule

`default_nettype wire
